/* hw/rtl/sbl_pkg.sv */
// ----------------------------------------------------------------------------
// sbl_pkg
// Types and constants shared by the serial boot loader receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [WordW-1:0] LOAD_ADDR_RST = 32'h0100_0000;
  localparam logic [WordW-1:0] SYNC_WORD_RST = 32'hf0f0_f0f0;
  localparam logic [WordW-1:0] WORD_BYTES    = 32'd4;
  localparam logic [ByteW-1:0] STATUS_DONE   = 8'h02;
  localparam int unsigned      CheckDiv      = 230;

  localparam logic [CfgIdxW-1:0] CFG_LOAD_ADDR = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_WORD = 8'd1;

  typedef struct packed {
    logic             ack_valid;
    logic             ack_failure;
    logic             write_valid;
    logic [WordW-1:0] write_address;
    logic [WordW-1:0] write_data;
    logic             flush_valid;
    logic [WordW-1:0] flush_address;
    logic             finished;
    logic             last;
  } sbl_result_t;

  // results caused by the item in the input register
  typedef struct packed {
    logic        r0_valid;
    logic        r1_valid;
    sbl_result_t r0;
    sbl_result_t r1;
  } sbl_step_t;

endpackage

`default_nettype wire

/* hw/rtl/sbl_frame_check.sv */
// ----------------------------------------------------------------------------
// sbl_frame_check
// Frame check: word modulo 230 compared with the check byte, by folding
// bytes with 256 = 26 (mod 230) and one final subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_frame_check import sbl_pkg::*; (
  input  wire logic [WordW-1:0] word_i,
  input  wire logic [ByteW-1:0] check_i,
  output logic                  match_o
);

  localparam logic [8:0] Div = 9'(CheckDiv);

  logic [16:0] x1;
  logic [13:0] x2;
  logic [10:0] x3;
  logic [8:0]  x4;
  logic [8:0]  rem;

  // 256^1, 256^2, 256^3 mod 230 = 26, 216, 96
  always_comb begin
    x1 = 17'(word_i[7:0]) + 17'(word_i[15:8]) * 17'd26
       + 17'(word_i[23:16]) * 17'd216 + 17'(word_i[31:24]) * 17'd96;
    x2 = 14'(x1[7:0]) + 14'(x1[16:8]) * 14'd26;
    x3 = 11'(x2[7:0]) + 11'(x2[13:8]) * 11'd26;
    x4 = 9'(x3[7:0]) + 9'(x3[10:8]) * 9'd26;
    rem = (x4 >= Div) ? (x4 - Div) : x4;
    match_o = (rem[7:0] == check_i);
  end

endmodule

`default_nettype wire

/* hw/rtl/sbl_core.sv */
// ----------------------------------------------------------------------------
// sbl_core
// Session state, configuration registers and result formation for one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_core import sbl_pkg::*; #(
  parameter int unsigned GROUP_WORDS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [WordW-1:0]   cfg_data_i,
  input  wire logic [WordW-1:0]   word_i,
  input  wire logic [ByteW-1:0]   check_i,
  input  wire logic [ByteW-1:0]   status_i,
  input  wire logic               adv_i,
  output sbl_step_t               step_o
);

  localparam int unsigned CntW = (GROUP_WORDS > 1) ? $clog2(GROUP_WORDS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(GROUP_WORDS - 1);

  logic [WordW-1:0] load_addr_q, sync_q;
  logic             loading_q, loading_d;
  logic [WordW-1:0] wp_q, wp_d, gs_q, gs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             good;

  sbl_frame_check u_check (
    .word_i  (word_i),
    .check_i (check_i),
    .match_o (good)
  );

  always_comb begin
    step_o    = '0;
    loading_d = loading_q;
    wp_d      = wp_q;
    gs_d      = gs_q;
    cnt_d     = cnt_q;
    if (!loading_q) begin
      if (word_i == sync_q) begin
        step_o.r0_valid     = 1'b1;
        step_o.r0.ack_valid = 1'b1;
        step_o.r0.last      = 1'b1;
        loading_d = 1'b1;
        wp_d      = load_addr_q;
        gs_d      = load_addr_q;
        cnt_d     = '0;
      end
    end else begin
      step_o.r0_valid     = 1'b1;
      step_o.r0.ack_valid = 1'b1;
      if (good) begin
        step_o.r0.write_valid   = 1'b1;
        step_o.r0.write_address = wp_q;
        step_o.r0.write_data    = word_i;
        wp_d = wp_q + WORD_BYTES;
        if (cnt_q >= CntLast) begin
          step_o.r0.flush_valid   = 1'b1;
          step_o.r0.flush_address = gs_q;
          gs_d  = wp_d;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        step_o.r0.ack_failure = 1'b1;
      end
      if (status_i == STATUS_DONE) begin
        step_o.r1_valid         = 1'b1;
        step_o.r1.flush_valid   = 1'b1;
        step_o.r1.flush_address = gs_d;
        step_o.r1.finished      = 1'b1;
        step_o.r1.last          = 1'b1;
        loading_d = 1'b0;
      end else begin
        step_o.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_addr_q <= LOAD_ADDR_RST;
      sync_q      <= SYNC_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOAD_ADDR: load_addr_q <= cfg_data_i;
        CFG_SYNC_WORD: sync_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q <= 1'b0;
      wp_q      <= LOAD_ADDR_RST;
      gs_q      <= LOAD_ADDR_RST;
      cnt_q     <= '0;
    end else if (adv_i) begin
      loading_q <= loading_d;
      wp_q      <= wp_d;
      gs_q      <= gs_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/serial_boot_loader_receiver.sv */
// ----------------------------------------------------------------------------
// serial_boot_loader_receiver
// Receives sync words and code frames, issues acknowledge, memory write,
// cache flush and finished requests.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   frame_word, check_byte, status_byte
// out      output     out_valid_o / out_stall_i ack, write, flush, finished, last
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request a cycle unless out_stall_i or a pending result holds the input:
// input register, single-pass frame logic, result register. A done frame
// yields two results and holds the input while the second drains from a
// pending register. No clearing after reset. out_stall_i holds the result
// register and, through it, the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_boot_loader_receiver import sbl_pkg::*; #(
  parameter int unsigned GROUP_WORDS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [WordW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [WordW-1:0]   frame_word_i,
  input  wire logic [ByteW-1:0]   check_byte_i,
  input  wire logic [ByteW-1:0]   status_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    ack_valid_o,
  output logic                    ack_failure_o,
  output logic                    write_valid_o,
  output logic [WordW-1:0]        write_address_o,
  output logic [WordW-1:0]        write_data_o,
  output logic                    flush_valid_o,
  output logic [WordW-1:0]        flush_address_o,
  output logic                    finished_o,
  output logic                    last_o
);

  logic             in_vld_q, in_vld_d;
  logic [WordW-1:0] word_q;
  logic [ByteW-1:0] check_q, status_q;
  logic             out_vld_q, out_vld_d, pend_q, pend_d;
  sbl_result_t      out_q, out_d, pend_res_q, pend_res_d;
  sbl_step_t        step;
  logic             take, out_free, adv, accept;

  assign cfg_ready_o = 1'b1;

  assign take       = out_vld_q && !out_stall_i;
  assign out_free   = !pend_q && (!out_vld_q || !out_stall_i);
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  sbl_core #(
    .GROUP_WORDS (GROUP_WORDS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .word_i      (word_q),
    .check_i     (check_q),
    .status_i    (status_q),
    .adv_i       (adv),
    .step_o      (step)
  );

  always_comb begin
    in_vld_d   = accept ? 1'b1 : (adv ? 1'b0 : in_vld_q);
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    pend_d     = pend_q;
    pend_res_d = pend_res_q;
    if (adv && step.r0_valid) begin
      out_vld_d  = 1'b1;
      out_d      = step.r0;
      pend_d     = step.r1_valid;
      pend_res_d = step.r1;
    end else if (pend_q && (!out_vld_q || take)) begin
      out_vld_d = 1'b1;
      out_d     = pend_res_q;
      pend_d    = 1'b0;
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q   <= frame_word_i;
      check_q  <= check_byte_i;
      status_q <= status_byte_i;
    end
    out_q      <= out_d;
    pend_res_q <= pend_res_d;
  end

  assign out_valid_o     = out_vld_q;
  assign ack_valid_o     = out_q.ack_valid;
  assign ack_failure_o   = out_q.ack_failure;
  assign write_valid_o   = out_q.write_valid;
  assign write_address_o = out_q.write_address;
  assign write_data_o    = out_q.write_data;
  assign flush_valid_o   = out_q.flush_valid;
  assign flush_address_o = out_q.flush_address;
  assign finished_o      = out_q.finished;
  assign last_o          = out_q.last;

  a_pend_behind_out : assert property (
    @(posedge clk_i) disable iff (!rst_ni) pend_q |-> out_vld_q
  ) else $error("pending result without a result in the output register");

  a_finished_shape : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && finished_o) |-> (last_o && flush_valid_o && !ack_valid_o)
  ) else $error("finished result malformed");

  a_write_ack_ok : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && write_valid_o) |-> (ack_valid_o && !ack_failure_o)
  ) else $error("write without success acknowledge");

  a_pend_holds_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (pend_q && in_vld_q) |-> in_stall_o
  ) else $error("input advanced over a pending result");

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_boot_loader_receiver. A directed list covers
// the idle sync search, good and bad frames, group flushes, done frames,
// pointer wrap and register extremes. A random phase follows: mostly sync
// words and load sessions of checksummed frames, plus noise, bad checks and
// register changes between sessions. A behavioural loader model predicts every
// result, checked field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbl_pkg::*;

  localparam int unsigned GROUP_WORDS = 4;
  localparam int ITEMS_TARGET = 1250;
  localparam int CALM_ITEMS   = 150;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_e;

  // cfg rows: word holds the write data, chk the register index
  typedef struct {
    row_kind_e   kind;
    logic [31:0] word;
    logic [7:0]  chk;
    logic [7:0]  st;
    int          n;
    sbl_result_t r0;
    sbl_result_t r1;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [WordW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [WordW-1:0]   frame_word_i = '0;
  logic [ByteW-1:0]   check_byte_i = '0;
  logic [ByteW-1:0]   status_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               ack_valid_o;
  logic               ack_failure_o;
  logic               write_valid_o;
  logic [WordW-1:0]   write_address_o;
  logic [WordW-1:0]   write_data_o;
  logic               flush_valid_o;
  logic [WordW-1:0]   flush_address_o;
  logic               finished_o;
  logic               last_o;

  serial_boot_loader_receiver #(.GROUP_WORDS(GROUP_WORDS)) u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .frame_word_i, .check_byte_i, .status_byte_i,
    .out_valid_o, .out_stall_i,
    .ack_valid_o, .ack_failure_o, .write_valid_o, .write_address_o, .write_data_o,
    .flush_valid_o, .flush_address_o, .finished_o, .last_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // loader model state
  logic [31:0] cfg_load_addr = LOAD_ADDR_RST;
  logic [31:0] cfg_sync_word = SYNC_WORD_RST;
  bit          loading = 1'b0;
  logic [31:0] wr_ptr = LOAD_ADDR_RST;
  logic [31:0] grp_start = LOAD_ADDR_RST;
  int          grp_cnt = 0;

  sbl_result_t pending_results[$];
  stim_row_t   dir_rows[$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          gap_pct = 30;
  int          stall_pct = 30;
  int          stall_left = 0;

  function automatic sbl_result_t res(input logic av, af, wv, input logic [31:0] wa, wd,
                                      input logic fv, input logic [31:0] fa,
                                      input logic fin, lst);
    sbl_result_t r;
    r = '{av, af, wv, wa, wd, fv, fa, fin, lst};
    return r;
  endfunction

  function automatic void add_row(input row_kind_e k, input logic [31:0] w,
                                  input logic [7:0] c, input logic [7:0] s,
                                  input int n = 0, input sbl_result_t r0 = '0,
                                  input sbl_result_t r1 = '0);
    stim_row_t r;
    r.kind = k;
    r.word = w;
    r.chk  = c;
    r.st   = s;
    r.n    = n;
    r.r0   = r0;
    r.r1   = r1;
    dir_rows.push_back(r);
  endfunction

  function automatic void set_register(input logic [CfgIdxW-1:0] idx, input logic [31:0] v);
    if (idx == CFG_LOAD_ADDR) cfg_load_addr = v;
    else if (idx == CFG_SYNC_WORD) cfg_sync_word = v;
  endfunction

  function automatic int step_loader(input logic [31:0] w, input logic [7:0] c,
                                     input logic [7:0] s,
                                     output sbl_result_t r0, output sbl_result_t r1);
    r0 = '0;
    r1 = '0;
    if (!loading) begin
      if (w != cfg_sync_word) return 0;
      loading   = 1'b1;
      wr_ptr    = cfg_load_addr;
      grp_start = cfg_load_addr;
      grp_cnt   = 0;
      r0.ack_valid = 1'b1;
      r0.last      = 1'b1;
      return 1;
    end
    r0.ack_valid = 1'b1;
    if ((w % CheckDiv) == c) begin
      r0.write_valid   = 1'b1;
      r0.write_address = wr_ptr;
      r0.write_data    = w;
      wr_ptr = wr_ptr + WORD_BYTES;
      if (grp_cnt >= GROUP_WORDS - 1) begin
        r0.flush_valid   = 1'b1;
        r0.flush_address = grp_start;
        grp_start = wr_ptr;
        grp_cnt   = 0;
      end else begin
        grp_cnt++;
      end
    end else begin
      r0.ack_failure = 1'b1;
    end
    if (s != STATUS_DONE) begin
      r0.last = 1'b1;
      return 1;
    end
    r1.flush_valid   = 1'b1;
    r1.flush_address = grp_start;
    r1.finished      = 1'b1;
    r1.last          = 1'b1;
    loading = 1'b0;
    return 2;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  // valid stays high after acceptance unless a random gap lowers it; the caller either sends again or lowers it
  task automatic send_item(output int n, input logic [31:0] w, input logic [7:0] c,
                           input logic [7:0] s, input bit use_typed = 1'b0,
                           input int typed_n = 0, input sbl_result_t t0 = '0,
                           input sbl_result_t t1 = '0);
    sbl_result_t p0, p1;
    in_valid_i    <= 1'b1;
    frame_word_i  <= w;
    check_byte_i  <= c;
    status_byte_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    n = step_loader(w, c, s, p0, p1);
    if (use_typed) begin
      n  = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n >= 1) pending_results.push_back(p0);
    if (n == 2) pending_results.push_back(p1);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // valid stays high; the caller lowers it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_register(idx, v);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 17);
    end
  end

  always @(posedge clk_i) begin : result_check
    sbl_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending, expected nothing, actual ack %b write %b flush %b fin %b",
                 $time, ack_valid_o, write_valid_o, flush_valid_o, finished_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("ack_valid", want.ack_valid, ack_valid_o);
        check_field("ack_failure", want.ack_failure, ack_failure_o);
        check_field("write_valid", want.write_valid, write_valid_o);
        check_field("write_address", want.write_address, write_address_o);
        check_field("write_data", want.write_data, write_data_o);
        check_field("flush_valid", want.flush_valid, flush_valid_o);
        check_field("flush_address", want.flush_address, flush_address_o);
        check_field("finished", want.finished, finished_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          n;
    int          useful;
    int          phase_items;
    int          phase_len;
    bit          cfg_open;
    logic [31:0] w;
    logic [7:0]  c;
    logic [7:0]  s;
    logic [31:0] v;

    // idle search and first session at reset settings
    add_row(ROW_TYPED, 32'h0000_0000, 8'd0, 8'd0, 0);
    add_row(ROW_TYPED, 32'hffff_ffff, 8'hff, 8'hff, 0);
    add_row(ROW_TYPED, SYNC_WORD_RST, 8'd0, 8'd0, 1, res(1, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(ROW_TYPED, 32'd0, 8'd0, 8'd0, 1,
            res(1, 0, 1, LOAD_ADDR_RST, 32'd0, 0, 0, 0, 1));
    add_row(ROW_ITEM, 32'hffff_ffff, 8'd195, 8'hfd);
    add_row(ROW_TYPED, 32'h1234_5678, 8'hff, 8'h00, 1, res(1, 1, 0, 0, 0, 0, 0, 0, 1));
    add_row(ROW_ITEM, 32'd230, 8'd0, 8'h01);
    add_row(ROW_ITEM, 32'd229, 8'd229, 8'hff);
    add_row(ROW_ITEM, 32'd1, 8'd1, STATUS_DONE);
    // bad frame that ends the session
    add_row(ROW_TYPED, SYNC_WORD_RST, 8'd0, 8'd0, 1, res(1, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(ROW_TYPED, 32'd3, 8'd4, STATUS_DONE, 2, res(1, 1, 0, 0, 0, 0, 0, 0, 0),
            res(0, 0, 0, 0, 0, 1, LOAD_ADDR_RST, 1, 1));
    // pointer wrap
    add_row(ROW_CFG, 32'hffff_fff8, CFG_LOAD_ADDR, 8'd0);
    add_row(ROW_CFG, 32'h0000_0000, CFG_SYNC_WORD, 8'd0);
    add_row(ROW_CFG, 32'h0000_0000, 8'hff, 8'd0);
    add_row(ROW_TYPED, 32'd0, 8'd0, 8'd0, 1, res(1, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(ROW_ITEM, 32'd10, 8'd10, 8'd0);
    add_row(ROW_ITEM, 32'd20, 8'd20, 8'd0);
    add_row(ROW_ITEM, 32'd30, 8'd30, 8'd0);
    add_row(ROW_ITEM, 32'd40, 8'd40, 8'd0);
    add_row(ROW_ITEM, 32'd50, 8'd50, STATUS_DONE);
    // all-ones registers
    add_row(ROW_CFG, 32'hffff_ffff, CFG_LOAD_ADDR, 8'd0);
    add_row(ROW_CFG, 32'hffff_ffff, CFG_SYNC_WORD, 8'd0);
    add_row(ROW_TYPED, 32'hffff_fffe, 8'd0, 8'd0, 0);
    add_row(ROW_TYPED, 32'hffff_ffff, 8'd0, 8'd0, 1, res(1, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(ROW_TYPED, 32'd0, 8'd0, STATUS_DONE, 2,
            res(1, 0, 1, 32'hffff_ffff, 32'd0, 0, 0, 0, 0),
            res(0, 0, 0, 0, 0, 1, 32'hffff_ffff, 1, 1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_open = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(dir_rows[i].chk, dir_rows[i].word);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(n, dir_rows[i].word, dir_rows[i].chk, dir_rows[i].st,
                  dir_rows[i].kind == ROW_TYPED, dir_rows[i].n, dir_rows[i].r0,
                  dir_rows[i].r1);
      end
    end

    useful      = 0;
    phase_items = 0;
    phase_len   = 0;
    while (useful < ITEMS_TARGET) begin
      if (phase_items >= phase_len && useful < ITEMS_TARGET - CALM_ITEMS) begin
        phase_items = 0;
        phase_len   = $urandom_range(40, 160);
        gap_pct     = pick_pct();
        stall_pct   = pick_pct();
        if ($urandom_range(0, 1) == 1) begin
          wait_idle();
          if ($urandom_range(0, 3) == 0)
            write_reg(8'($urandom_range(CFG_SYNC_WORD + 1, 255)), $urandom);
          case ($urandom_range(0, 4))
            0: v = '0;
            1: v = '1;
            2: v = 32'hffff_fff0;
            3: v = $urandom & ~32'h3;
            default: v = $urandom;
          endcase
          write_reg(CFG_LOAD_ADDR, v);
          case ($urandom_range(0, 3))
            0: v = '0;
            1: v = '1;
            default: v = $urandom;
          endcase
          write_reg(CFG_SYNC_WORD, v);
          cfg_valid_i <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          wait_idle();
        end
      end
      if (useful >= ITEMS_TARGET - CALM_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end

      if (!loading) begin
        case ($urandom_range(0, 7))
          0: w = $urandom;
          1: w = cfg_sync_word ^ (32'h1 << $urandom_range(0, 31));
          2: w = ~cfg_sync_word;
          default: w = cfg_sync_word;
        endcase
        c = 8'($urandom);
        s = 8'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: w = $urandom_range(0, 460);
          1: w = 32'hffff_ffff - $urandom_range(0, 300);
          default: w = $urandom;
        endcase
        case ($urandom_range(0, 19))
          0: c = 8'($urandom_range(230, 255));
          1, 2: c = 8'($urandom);
          default: c = 8'(w % CheckDiv);
        endcase
        if ($urandom_range(0, 99) < 6) begin
          s = STATUS_DONE;
        end else begin
          s = 8'($urandom);
          if (s == STATUS_DONE) s = ~STATUS_DONE;
        end
      end
      send_item(n, w, c, s);
      if (n > 0) begin
        useful++;
        phase_items++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
